FILE: src/dzr_pkg.sv
package dzr_pkg;

  localparam int AXIS_BITS = 16;
  localparam int DZ_BITS = AXIS_BITS + 1;

  typedef enum logic [0:0] {
    CFG_DEADZONE_LEVEL = 1'b0,
    CFG_RADIAL_MODE    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] axis_x;
    logic signed [AXIS_BITS-1:0] axis_y;
  } axis_in_t;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] shaped_x;
    logic signed [AXIS_BITS-1:0] shaped_y;
    logic                        inside_zone;
  } axis_out_t;

  typedef struct packed {
    logic                 neg_x;
    logic                 neg_y;
    logic                 pass;
    logic                 radial;
    logic                 zero;
    logic                 in_zone;
    logic [AXIS_BITS-1:0] ax;
    logic [AXIS_BITS-1:0] ay;
  } side_t;

  typedef struct packed {
    logic                 neg;
    logic                 pass;
    logic                 zero;
    logic                 in_zone;
    logic [AXIS_BITS-1:0] a;
  } div_side_t;

endpackage

FILE: src/dzr_sqrt.sv
module dzr_sqrt
  import dzr_pkg::*;
#(
  parameter int W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [2*W-1:0] radicand_i,
  input  side_t          side_i,
  output logic           valid_o,
  output logic [W-1:0]   root_o,
  output side_t          side_o
);

  localparam int RW = W + 3;

  logic           v_q    [W];
  logic [RW-1:0]  rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] n_q    [W];
  side_t          side_q [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic           v_in;
    logic [RW-1:0]  rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] n_in;
    side_t          side_in;
    logic [RW-1:0]  cur;
    logic [RW-1:0]  trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = radicand_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign n_in    = n_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign cur   = {rem_in[RW-3:0], n_in[2*W-1:2*W-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? cur - trial : cur;
      root_q[i] <= {root_in[W-2:0], ge};
      n_q[i]    <= {n_in[2*W-3:0], 2'b00};
      side_q[i] <= side_in;
    end
  end

  assign valid_o = v_q[W-1];
  assign root_o  = root_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

FILE: src/dzr_div.sv
module dzr_div
  import dzr_pkg::*;
#(
  parameter int W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [2*W-1:0] num_i,
  input  logic [2*W-1:0] den_i,
  input  div_side_t      side_i,
  output logic           valid_o,
  output logic [W-1:0]   mag_o,
  output div_side_t      side_o
);

  localparam int DW = 2 * W;
  localparam logic [W-1:0] MAX_MAG = {1'b0, {(W-1){1'b1}}};

  logic            v_q    [W];
  logic [DW-1:0]   r_q    [W];
  logic [DW-1:0]   d_q    [W];
  logic [W-2:0]    res_q  [W];
  logic            sat_q  [W];
  div_side_t       side_q [W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]    <= num_i;
    d_q[0]    <= den_i;
    res_q[0]  <= '0;
    sat_q[0]  <= num_i >= den_i;
    side_q[0] <= side_i;
  end

  for (genvar i = 1; i < W; i++) begin : g_stage
    logic [DW-1:0] r2;
    logic          ge;

    assign r2 = {r_q[i-1][DW-2:0], 1'b0};
    assign ge = r2 >= d_q[i-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[i]    <= ge ? r2 - d_q[i-1] : r2;
      d_q[i]    <= d_q[i-1];
      res_q[i]  <= {res_q[i-1][W-3:0], ge};
      sat_q[i]  <= sat_q[i-1];
      side_q[i] <= side_q[i-1];
    end
  end

  assign valid_o = v_q[W-1];
  assign mag_o   = sat_q[W-1] ? MAX_MAG : {1'b0, res_q[W-1]};
  assign side_o  = side_q[W-1];

endmodule

FILE: src/stick_deadzone_rescaler_top.sv
// Channel   Direction  Handshake          Payload
// command   in         start_i / busy_o   item_i (axis_x, axis_y)
// result    out        done_o strobe      result_o (shaped_x, shaped_y, inside_zone)
// config    in         cfg_we_i           cfg_idx_i, cfg_data_i
// A sample may be started in every cycle; busy_o never rises.
// Each result passes the input and square registers, the bit-per-stage square root
// pipeline, a multiply register, the bit-per-stage dividers and the output register.
// Reset clears all valid bits and sets the deadzone to 0 and radial mode on.
// The receiver cannot stall, so the pipeline advances in every cycle.
module stick_deadzone_rescaler_top
  import dzr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  axis_in_t             item_i,
  output logic                 done_o,
  output axis_out_t            result_o,
  input  logic                 cfg_we_i,
  input  cfg_idx_e             cfg_idx_i,
  input  logic [DZ_BITS-1:0]   cfg_data_i
);

  localparam int W = AXIS_BITS;
  localparam int LAT = 2 * W + 4;
  localparam logic [W-1:0] FULL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_MAG = {1'b0, {(W-1){1'b1}}};

  logic signed [DZ_BITS-1:0] dz_q;
  logic                      radial_q;
  logic [2*W-1:0]            dzsq_q;
  logic [W-1:0]              dzm;

  assign busy_o = 1'b0;
  assign dzm = dz_q[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q     <= '0;
      radial_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEADZONE_LEVEL: dz_q     <= cfg_data_i;
        CFG_RADIAL_MODE:    radial_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    dzsq_q <= (2*W)'(dzm) * (2*W)'(dzm);
  end

  logic         s0_v_q;
  logic [W-1:0] s0_ax_q, s0_ay_q;
  logic         s0_negx_q, s0_negy_q, s0_pass_q, s0_radial_q;
  logic         pass_d;

  assign pass_d = (dz_q <= 0) || (dz_q >= $signed({1'b0, FULL}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_negx_q   <= item_i.axis_x[W-1];
    s0_negy_q   <= item_i.axis_y[W-1];
    s0_ax_q     <= item_i.axis_x[W-1] ? W'(~item_i.axis_x + 1'b1) : W'(item_i.axis_x);
    s0_ay_q     <= item_i.axis_y[W-1] ? W'(~item_i.axis_y + 1'b1) : W'(item_i.axis_y);
    s0_pass_q   <= pass_d;
    s0_radial_q <= radial_q;
  end

  logic           s1_v_q;
  logic [2*W-1:0] s1_sq_q;
  side_t          s1_side_q;
  logic [2*W-1:0] sq_d;
  logic           rad_in, pa_in;

  assign sq_d = (2*W)'(s0_ax_q) * (2*W)'(s0_ax_q) + (2*W)'(s0_ay_q) * (2*W)'(s0_ay_q);
  assign rad_in = s0_radial_q && !s0_pass_q && (sq_d <= dzsq_q);
  assign pa_in = !s0_radial_q && !s0_pass_q && (s0_ax_q <= dzm) && (s0_ay_q <= dzm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sq_q           <= sq_d;
    s1_side_q.neg_x   <= s0_negx_q;
    s1_side_q.neg_y   <= s0_negy_q;
    s1_side_q.pass    <= s0_pass_q;
    s1_side_q.radial  <= s0_radial_q;
    s1_side_q.zero    <= rad_in;
    s1_side_q.in_zone <= rad_in || pa_in;
    s1_side_q.ax      <= s0_ax_q;
    s1_side_q.ay      <= s0_ay_q;
  end

  logic         rt_v;
  logic [W-1:0] rt_root;
  side_t        rt_side;

  dzr_sqrt #(.W(W)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_v_q),
    .radicand_i (s1_sq_q),
    .side_i     (s1_side_q),
    .valid_o    (rt_v),
    .root_o     (rt_root),
    .side_o     (rt_side)
  );

  logic           m_v_q;
  logic [2*W-1:0] m_qx_q, m_qy_q, m_d_q;
  div_side_t      m_sx_q, m_sy_q;
  logic [W-1:0]   live, fd;

  assign live = (rt_root > dzm) ? rt_root - dzm : '0;
  assign fd   = FULL - dzm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= rt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rt_side.radial) begin
      m_qx_q <= (2*W)'(rt_side.ax) * (2*W)'(live);
      m_qy_q <= (2*W)'(rt_side.ay) * (2*W)'(live);
      m_d_q  <= (2*W)'(fd) * (2*W)'(rt_root);
    end else begin
      m_qx_q <= (rt_side.ax > dzm) ? (2*W)'(rt_side.ax - dzm) : '0;
      m_qy_q <= (rt_side.ay > dzm) ? (2*W)'(rt_side.ay - dzm) : '0;
      m_d_q  <= (2*W)'(fd);
    end
    m_sx_q <= '{neg: rt_side.neg_x, pass: rt_side.pass, zero: rt_side.zero,
                in_zone: rt_side.in_zone, a: rt_side.ax};
    m_sy_q <= '{neg: rt_side.neg_y, pass: rt_side.pass, zero: rt_side.zero,
                in_zone: rt_side.in_zone, a: rt_side.ay};
  end

  logic         dx_v, dy_v;
  logic [W-1:0] dx_mag, dy_mag;
  div_side_t    dx_side, dy_side;

  dzr_div #(.W(W)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_v_q),
    .num_i   (m_qx_q),
    .den_i   (m_d_q),
    .side_i  (m_sx_q),
    .valid_o (dx_v),
    .mag_o   (dx_mag),
    .side_o  (dx_side)
  );

  dzr_div #(.W(W)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_v_q),
    .num_i   (m_qy_q),
    .den_i   (m_d_q),
    .side_i  (m_sy_q),
    .valid_o (dy_v),
    .mag_o   (dy_mag),
    .side_o  (dy_side)
  );

  logic [W-1:0] mag_x, mag_y;

  always_comb begin
    priority if (dx_side.pass) begin
      mag_x = (dx_side.a > MAX_MAG) ? MAX_MAG : dx_side.a;
      mag_y = (dy_side.a > MAX_MAG) ? MAX_MAG : dy_side.a;
    end else if (dx_side.zero) begin
      mag_x = '0;
      mag_y = '0;
    end else begin
      mag_x = dx_mag;
      mag_y = dy_mag;
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o.shaped_x    <= dx_side.neg ? $signed(W'(~mag_x + 1'b1)) : $signed(mag_x);
    result_o.shaped_y    <= dy_side.neg ? $signed(W'(~mag_y + 1'b1)) : $signed(mag_y);
    result_o.inside_zone <= dx_side.in_zone;
  end

  assign done_o = done_q;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx_v == dy_v) else $error("divider lanes out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT)) else $error("result without matching start");

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.inside_zone) |->
      (result_o.shaped_x == '0 && result_o.shaped_y == '0))
    else $error("inside zone with nonzero output");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.shaped_x != $signed(FULL) && result_o.shaped_y != $signed(FULL)))
    else $error("output beyond saturation limit");
`endif

endmodule
